// File: hw/rtl/nla_pkg.sv
`timescale 1ns / 1ps

package nla_pkg;

	// Table geometry and field widths.
	localparam int MaxLandmarks = 64;
	localparam int IdxW         = $clog2(MaxLandmarks);
	localparam int CountW       = 7;
	localparam int CoordW       = 24;
	localparam int DiffW        = CoordW + 1;
	localparam int SqW          = 2 * CoordW + 1;
	localparam int DistW        = SqW + 1;

	// The distance unit has two register stages ahead of the running minimum.
	localparam int DrainCycles  = 2;
	localparam int DrainW       = $clog2(DrainCycles);

	// Action codes carried in the input beat.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [IdxW-1:0]          idx_t;
	typedef logic [CountW-1:0]        count_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} landmark_t;

	// Control handed from the sequencer to the distance unit each cycle.
	typedef struct packed {
		logic clear;
		logic valid;
		idx_t index;
	} nla_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} nla_state_t;

endpackage

// File: hw/rtl/nla_if.sv
`timescale 1ns / 1ps

// Input channel: one write or query per beat.
interface nla_cmd_if;
	logic                   valid;
	logic                   ready;
	logic                   action;
	logic [nla_pkg::IdxW-1:0] slot;
	nla_pkg::coord_t        point_x;
	nla_pkg::coord_t        point_y;

	modport source (output valid, action, slot, point_x, point_y, input ready);
	modport sink   (input valid, action, slot, point_x, point_y, output ready);
endinterface

// Result channel: one nearest index per query.
interface nla_res_if;
	logic                   valid;
	logic                   ready;
	logic [nla_pkg::IdxW-1:0] nearest_index;

	modport source (output valid, nearest_index, input ready);
	modport sink   (input valid, nearest_index, output ready);
endinterface

// Configuration channel: writes the landmark count register.
interface nla_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [nla_pkg::CountW-1:0] landmark_count;

	modport source (output valid, landmark_count, input ready);
	modport sink   (input valid, landmark_count, output ready);
endinterface

// File: hw/rtl/nla_cell.sv
`timescale 1ns / 1ps

module nla_cell (
	input  logic               clk,
	input  logic               shift_en,
	input  logic               wr_en,
	input  nla_pkg::landmark_t wr_data,
	input  nla_pkg::landmark_t nbr,
	output nla_pkg::landmark_t data
);
	import nla_pkg::*;

	landmark_t entry_q;

	// One table entry: loaded by a write, or takes its neighbor's entry on a shift.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_data;
		end else if (shift_en) begin
			entry_q <= nbr;
		end
	end

	assign data = entry_q;

endmodule

// File: hw/rtl/nla_dist.sv
`timescale 1ns / 1ps

module nla_dist (
	input  logic               clk,
	input  logic               arst_n,
	input  nla_pkg::nla_ctl_t  ctl,
	input  nla_pkg::landmark_t head,
	input  nla_pkg::coord_t    qx,
	input  nla_pkg::coord_t    qy,
	output nla_pkg::idx_t      best_index
);
	import nla_pkg::*;

	logic signed [DiffW-1:0]   dx;
	logic signed [DiffW-1:0]   dy;
	logic signed [DiffW-1:0]   dx_s1;
	logic signed [DiffW-1:0]   dy_s1;
	logic                      valid_s1;
	idx_t                      index_s1;
	logic signed [2*DiffW-1:0] sq_x;
	logic signed [2*DiffW-1:0] sq_y;
	logic [SqW-1:0]            sq_x_s2;
	logic [SqW-1:0]            sq_y_s2;
	logic                      valid_s2;
	idx_t                      index_s2;
	logic [DistW-1:0]          sum_sq;
	logic [DistW-1:0]          best_dist_q;
	idx_t                      best_index_q;
	logic                      take;

	// Stage 1: coordinate differences against the query point.
	assign dx = DiffW'(head.x) - DiffW'(qx);
	assign dy = DiffW'(head.y) - DiffW'(qy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= dx;
		dy_s1    <= dy;
		index_s1 <= ctl.index;
	end

	// Stage 2: squares of the differences.
	assign sq_x = dx_s1 * dx_s1;
	assign sq_y = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s2  <= sq_x[SqW-1:0];
		sq_y_s2  <= sq_y[SqW-1:0];
		index_s2 <= index_s1;
	end

	// Stage 3: sum and strict compare; entry 0, when searched, seeds the minimum.
	assign sum_sq = DistW'(sq_x_s2) + DistW'(sq_y_s2);
	assign take   = valid_s2 && ((index_s2 == '0) || (sum_sq < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_index_q <= '0;
		end else if (ctl.clear) begin
			best_index_q <= '0;
		end else if (take) begin
			best_index_q <= index_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= sum_sq;
		end
	end

	assign best_index = best_index_q;

endmodule

// File: hw/rtl/nearest_landmark_association_top.sv
`timescale 1ns / 1ps

// Nearest-landmark association. Landmarks live in a ring of 64 cells; a write beat
// loads one cell. A query beat rotates the whole ring once past a single distance
// unit, one entry per cycle, then drains the distance pipeline and registers the
// result beat; the next beat is taken only once that result has entered the output
// register, which waits while an earlier result is unaccepted. The squared distance
// is compared strictly, so the lowest index wins a tie, and an empty table answers
// index 0. A landmark count above 64 searches all 64 entries.
module nearest_landmark_association_top (
	input logic       clk,
	input logic       arst_n,
	nla_cmd_if.sink   cmd,
	nla_res_if.source result,
	nla_cfg_if.sink   cfg
);
	import nla_pkg::*;

	nla_state_t          state_q;
	idx_t                step_q;
	logic [DrainW-1:0]   drain_q;
	count_t              count_q;
	count_t              count_eff;
	coord_t              qx_q;
	coord_t              qy_q;
	logic                res_valid_q;
	idx_t                res_index_q;
	logic                cmd_fire;
	logic                query_fire;
	logic                write_fire;
	logic                shift_en;
	logic                res_free;
	nla_ctl_t            ctl;
	idx_t                best_index;
	landmark_t           wr_data;
	landmark_t           cell_data [MaxLandmarks];

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign query_fire = cmd_fire && (cmd.action == ACT_QUERY);
	assign write_fire = cmd_fire && (cmd.action == ACT_WRITE);
	assign shift_en   = (state_q == ST_SCAN);
	assign res_free   = !res_valid_q || result.ready;
	assign wr_data    = '{x: cmd.point_x, y: cmd.point_y};

	// Landmark count register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.landmark_count;
		end
	end

	assign count_eff = (count_q > count_t'(MaxLandmarks)) ? count_t'(MaxLandmarks) : count_q;

	// Ring of landmark cells; cell 0 is the head read by the distance unit.
	for (genvar i = 0; i < MaxLandmarks; i++) begin : g_cell
		localparam int Next = (i + 1) % MaxLandmarks;

		nla_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.wr_en    (write_fire && (cmd.slot == idx_t'(i))),
			.wr_data  (wr_data),
			.nbr      (cell_data[Next]),
			.data     (cell_data[i])
		);
	end

	// Query point held for the whole scan.
	always_ff @(posedge clk) begin
		if (query_fire) begin
			qx_q <= cmd.point_x;
			qy_q <= cmd.point_y;
		end
	end

	// Sequencer: one full rotation, pipeline drain, then hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (query_fire) begin
						state_q <= ST_SCAN;
						step_q  <= '0;
					end
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					if (step_q == idx_t'(MaxLandmarks - 1)) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == DrainW'(DrainCycles - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Tag for the entry at the head: searched only below the landmark count.
	assign ctl.clear = query_fire;
	assign ctl.valid = shift_en && (count_t'(step_q) < count_eff);
	assign ctl.index = step_q;

	nla_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.head       (cell_data[0]),
		.qx         (qx_q),
		.qy         (qy_q),
		.best_index (best_index)
	);

	// Output register for the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && res_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && res_free) begin
			res_index_q <= best_index;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.nearest_index = res_index_q;

	// A new result beat is only raised out of the done state.
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	// A query starts its scan at the head of the ring.
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		query_fire |=> (state_q == ST_SCAN) && (step_q == '0))
		else $error("scan did not start at entry zero");

	// The scan ends after exactly one full rotation.
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && (step_q == idx_t'(MaxLandmarks - 1)) |=> (state_q == ST_DRAIN))
		else $error("scan did not end after one rotation");

	// No entry is written while the ring is rotating.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		shift_en |-> !write_fire)
		else $error("write during rotation");

endmodule

// File: sim/tb_nearest_landmark_association_top.sv
`timescale 1ns / 1ps

module tb_nearest_landmark_association_top;
	import nla_pkg::*;

	localparam int RandomItems = 1250;
	localparam int CycleLimit  = 1000000;
	localparam int SettleWait  = 8;
	localparam int DrainWait   = 100;
	localparam int LongHold    = 800;

	typedef struct packed {
		logic   action;
		idx_t   slot;
		coord_t point_x;
		coord_t point_y;
	} cmd_beat_t;

	typedef enum int {
		COORD_FULL,
		COORD_EDGE,
		COORD_CLUSTER
	} coord_style_e;

	logic      clk;
	logic      arst_n     = 1'b0;
	logic      cmd_valid  = 1'b0;
	cmd_beat_t cmd_beat   = '0;
	logic      res_ready  = 1'b0;
	logic      cfg_valid  = 1'b0;
	count_t    cfg_count  = '0;

	nla_cmd_if cmd_if ();
	nla_res_if res_if ();
	nla_cfg_if cfg_if ();

	assign cmd_if.valid          = cmd_valid;
	assign cmd_if.action         = cmd_beat.action;
	assign cmd_if.slot           = cmd_beat.slot;
	assign cmd_if.point_x        = cmd_beat.point_x;
	assign cmd_if.point_y        = cmd_beat.point_y;
	assign res_if.ready          = res_ready;
	assign cfg_if.valid          = cfg_valid;
	assign cfg_if.landmark_count = cfg_count;

	nearest_landmark_association_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	// Beats waiting for the driver, and the indexes the block still owes us.
	cmd_beat_t pending_beats[$];
	idx_t      due_index[$];

	// Predictor state: our own copy of the landmark map and the search count.
	coord_t map_x[MaxLandmarks];
	coord_t map_y[MaxLandmarks];
	count_t search_count = '0;

	int mismatches   = 0;
	int results_seen = 0;
	int cycle_count  = 0;

	// Stimulus-side record of which map entries hold a written landmark.
	bit slot_loaded[MaxLandmarks];
	int random_items = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Strict compare of squared distance, so the lowest index wins a tie.
	function automatic idx_t nearest_landmark(coord_t px, coord_t py);
		int     span;
		int     best_j;
		longint dx;
		longint dy;
		longint sq_dist;
		longint best_dist;
		span      = (search_count > MaxLandmarks) ? MaxLandmarks : int'(search_count);
		best_j    = 0;
		best_dist = 0;
		for (int j = 0; j < span; j++) begin
			dx      = longint'(map_x[j]) - longint'(px);
			dy      = longint'(map_y[j]) - longint'(py);
			sq_dist = dx * dx + dy * dy;
			if (j == 0 || sq_dist < best_dist) begin
				best_dist = sq_dist;
				best_j    = j;
			end
		end
		return idx_t'(best_j);
	endfunction

	function automatic coord_t pick_coord(coord_style_e style);
		coord_t v;
		case (style)
			COORD_EDGE: begin
				case ($urandom_range(0, 4))
					0:       v = 24'sh7FFFFF;
					1:       v = 24'sh800000;
					2:       v = 24'sh000000;
					3:       v = 24'shFFFFFF;
					default: v = 24'sh000001;
				endcase
			end
			COORD_CLUSTER: v = coord_t'(int'($urandom_range(0, 32)) - 16);
			default:       v = coord_t'($urandom);
		endcase
		return v;
	endfunction

	function automatic coord_style_e pick_style(coord_style_e phase_style);
		coord_style_e s;
		if ($urandom_range(0, 9) < 7) begin
			s = phase_style;
		end else begin
			s = coord_style_e'($urandom_range(0, 2));
		end
		return s;
	endfunction

	task automatic push_write(idx_t slot, coord_t px, coord_t py);
		cmd_beat_t b;
		b.action  = ACT_WRITE;
		b.slot    = slot;
		b.point_x = px;
		b.point_y = py;
		pending_beats.insert(pending_beats.size(), b);
		slot_loaded[slot] = 1'b1;
	endtask

	task automatic push_query(coord_t px, coord_t py);
		cmd_beat_t b;
		b.action  = ACT_QUERY;
		b.slot    = idx_t'($urandom);
		b.point_x = px;
		b.point_y = py;
		pending_beats.insert(pending_beats.size(), b);
	endtask

	// Wait until every beat is taken and every index has come back, then let a
	// trailing write finish inside the block. The check runs on the falling edge
	// so that the driver and monitor updates of the rising edge are settled.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_beats.size() != 0 || cmd_valid || due_index.size() != 0);
		repeat (SettleWait) @(posedge clk);
	endtask

	task automatic set_count(count_t value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_count <= value;
		do begin
			@(posedge clk);
		end while (!cfg_if.ready);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed corners first, then random phases at several counts.
	initial begin
		count_t       new_count;
		int           span;
		int           phase_no;
		int           phase_len;
		coord_style_e phase_style;
		coord_style_e s;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table right after reset answers index 0.
		push_query(24'sh7FFFFF, 24'sh7FFFFF);
		push_query(24'sh800000, 24'sh800000);

		// Extreme corners, a duplicated point for a tie, and the top slot.
		push_write(6'd0, 24'sh800000, 24'sh7FFFFF);
		push_write(6'd1, 24'sh7FFFFF, 24'sh800000);
		push_write(6'd2, 24'sh000000, 24'sh000000);
		push_write(6'd3, 24'sh000000, 24'sh000000);
		push_write(6'd63, 24'sh7FFFFF, 24'sh7FFFFF);
		set_count(7'd4);
		push_query(24'sh800000, 24'sh7FFFFF);
		push_query(24'sh7FFFFF, 24'sh800000);
		push_query(24'sh000000, 24'sh000000);
		push_query(24'sh000001, 24'shFFFFFF);
		push_query(24'sh7FFFFF, 24'sh7FFFFF);
		push_query(24'sh800000, 24'sh800000);
		push_query(24'sh800000, 24'sh000000);
		set_count(7'd1);
		push_query(24'sh7FFFFF, 24'sh800000);
		push_query(24'sh000000, 24'sh000000);

		phase_no = 0;
		while (random_items < RandomItems) begin
			// The first phases force the extremes of the count register.
			case (phase_no)
				0: new_count = 7'd64;
				1: new_count = 7'd127;
				2: new_count = 7'd0;
				3: new_count = 7'd65;
				default: begin
					case ($urandom_range(0, 9))
						0:       new_count = 7'd0;
						1:       new_count = 7'd1;
						2:       new_count = 7'd64;
						3:       new_count = 7'd127;
						4:       new_count = count_t'($urandom_range(65, 126));
						default: new_count = count_t'($urandom_range(2, 63));
					endcase
				end
			endcase
			phase_no++;
			set_count(new_count);
			phase_style = coord_style_e'($urandom_range(0, 2));

			// Every entry inside the search range gets a landmark before any query.
			span = (new_count > MaxLandmarks) ? MaxLandmarks : int'(new_count);
			for (int j = 0; j < span; j++) begin
				if (!slot_loaded[j]) begin
					s = pick_style(phase_style);
					push_write(idx_t'(j), pick_coord(s), pick_coord(s));
					random_items++;
				end
			end

			phase_len = $urandom_range(30, 120);
			repeat (phase_len) begin
				s = pick_style(phase_style);
				if ($urandom_range(0, 9) < 3) begin
					push_write(idx_t'($urandom), pick_coord(s), pick_coord(s));
				end else begin
					push_query(pick_coord(s), pick_coord(s));
				end
				random_items++;
			end
		end

		wait_idle();
		repeat (DrainWait) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Command driver: bursts of beats separated by random gaps.
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_if.ready) begin
			if (gap_left != 0) begin
				cmd_valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (pending_beats.size() != 0) begin
				cmd_beat  <= pending_beats.pop_front();
				cmd_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 8);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result receiver: calm and choppy stretches, plus one long hold-off while
	// the driver still has beats to offer, so the block backs up into its input.
	int stall_left = 0;
	int mode_left  = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	bit choppy     = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			res_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= 100 && pending_beats.size() > 8) begin
			hold_done <= 1'b1;
			hold_left <= LongHold;
			res_ready <= 1'b0;
		end else if (stall_left != 0) begin
			res_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			if (mode_left == 0) begin
				choppy    <= !choppy;
				mode_left <= $urandom_range(300, 2000);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (choppy && $urandom_range(0, 3) == 0) begin
				stall_left <= $urandom_range(1, 90);
				res_ready  <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Monitor: update the predictor on accepted beats and check each result.
	always @(posedge clk) begin
		idx_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_if.ready) begin
				search_count = cfg_count;
			end
			if (cmd_valid && cmd_if.ready) begin
				if (cmd_beat.action == ACT_WRITE) begin
					map_x[cmd_beat.slot] = cmd_beat.point_x;
					map_y[cmd_beat.slot] = cmd_beat.point_y;
				end else begin
					due_index.insert(due_index.size(),
						nearest_landmark(cmd_beat.point_x, cmd_beat.point_y));
				end
			end
			if (res_if.valid && res_ready) begin
				results_seen++;
				if (due_index.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, expected none, got index %0d",
						$time, res_if.nearest_index);
				end else begin
					want = due_index.pop_front();
					if (res_if.nearest_index !== want) begin
						mismatches++;
						$display("%0t: nearest_index expected %0d, got %0d",
							$time, want, res_if.nearest_index);
					end
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
